// ===== sv/htc_pkg.sv =====
// Shared types and constants of the heater temperature controller.
// Used by the RTL modules and the testbench.
package htc_pkg;

   localparam int FILTER_SHIFT_DEF = 5;
   localparam int GAIN_SHIFT_DEF   = 8;

   localparam int ADC_W  = 12;
   localparam int TEMP_W = 9;
   localparam int DUTY_W = 10;
   localparam int OPA_W  = 18;
   localparam int OPB_W  = 16;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int SUM_W  = 36;
   localparam int CNT_W  = $clog2(OPB_W);

   localparam logic [ADC_W-1:0] ADC_OPEN  = 12'd4080;
   localparam logic [ADC_W-1:0] ADC_SHORT = 12'd50;

   localparam int NCAL = 4;
   localparam logic [10:0] CAL_TEMP [NCAL] = '{11'd23, 11'd200, 11'd310, 11'd450};
   localparam logic [10:0] CAL_ADC  [NCAL] = '{11'd447, 11'd770, 11'd974, 11'd1180};

   localparam logic [2:0] CSR_TARGET_C   = 3'd0;
   localparam logic [2:0] CSR_BOOST_THR  = 3'd1;
   localparam logic [2:0] CSR_KP         = 3'd2;
   localparam logic [2:0] CSR_KI         = 3'd3;
   localparam logic [2:0] CSR_KD         = 3'd4;
   localparam logic [2:0] CSR_INT_MIN    = 3'd5;
   localparam logic [2:0] CSR_INT_MAX    = 3'd6;
   localparam logic [2:0] CSR_OUTPUT_MAX = 3'd7;

   localparam logic ALU_MUL = 1'b0;
   localparam logic ALU_DIV = 1'b1;

   typedef struct packed {
      logic start;
      logic op;
   } alu_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_sts_type;

endpackage

// ===== sv/heater_temperature_controller.sv =====
// After a beat is accepted the temperature and target conversions run; when off, faulted or in boost
// the result is then loaded, else the PID terms run first. The next beat is taken the cycle after the
// result is loaded, so no new beat is taken while one is in work, nor while the result side stalls.
// Each multiply or divide runs on the one shared bit-serial unit.
// Reset (synchronous, active high) loads register defaults, heater off, fault set,
// filter, integral and last measurement cleared.
module heater_temperature_controller #(
   parameter int FILTER_SHIFT = htc_pkg::FILTER_SHIFT_DEF,
   parameter int GAIN_SHIFT   = htc_pkg::GAIN_SHIFT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_raw_adc,
   input  logic        req_toggle_power,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_pwm_duty,
   output logic [11:0] rsp_measured_adc,
   output logic [8:0]  rsp_measured_temp_c,
   output logic        rsp_heater_on,
   output logic        rsp_sensor_fault,
   output logic        rsp_fault_kind,
   output logic        rsp_boost_active,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int ACC_W = htc_pkg::ADC_W + FILTER_SHIFT;

   localparam logic [3:0] ST_IDLE = 4'd0, ST_TMUL = 4'd1, ST_TDIV = 4'd2, ST_SMUL = 4'd3,
                          ST_SDIV = 4'd4, ST_DECIDE = 4'd5, ST_KP = 4'd6, ST_KI = 4'd7,
                          ST_KD = 4'd8, ST_SCALE = 4'd9, ST_DONE = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic               issued_ff, issued_in;
   logic [8:0]         sp_ff, boost_thr_ff;
   logic [15:0]        kp_ff, kd_ff;
   logic [11:0]        ki_ff;
   logic signed [15:0] imin_ff, imax_ff;
   logic [9:0]         omax_ff;
   logic               en_ff, en_in, fault_ff, fault_in, kind_ff, kind_in;
   logic [ACC_W-1:0]   facc_ff, facc_in;
   logic signed [15:0] integ_ff, integ_in;
   logic [11:0]        last_ff, last_in, meas_ff, meas_in;
   logic [8:0]         temp_ff, temp_in;
   logic [10:0]        spadc_ff, spadc_in;
   logic [15:0]        quot_ff, quot_in;
   logic signed [12:0] e_ff, e_in;
   logic signed [htc_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [9:0]         duty_ff, duty_in;
   logic               boost_ff, boost_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [9:0]         o_duty_ff, o_duty_in;
   logic [11:0]        o_meas_ff, o_meas_in;
   logic [8:0]         o_temp_ff, o_temp_in;
   logic               o_en_ff, o_en_in, o_fault_ff, o_fault_in;
   logic               o_kind_ff, o_kind_in, o_boost_ff, o_boost_in;

   htc_pkg::alu_ctl_type              alu_ctl;
   htc_pkg::alu_sts_type              alu_sts;
   logic signed [htc_pkg::OPA_W-1:0]  alu_a;
   logic [htc_pkg::OPB_W-1:0]         alu_b;
   logic signed [htc_pkg::PROD_W-1:0] alu_r;

   logic               accept;
   logic [ACC_W-1:0]   scaled, fupd, fnew;
   logic signed [ACC_W:0] fdiff, fstep;
   logic               f_open, f_short;
   logic [10:0]        t_base, t_off, t_mulf, t_div;
   logic [10:0]        s_base, s_off, s_mulf, s_div;
   logic signed [16:0] iacc;
   logic signed [16:0] iclamp;
   logic signed [12:0] dmeas;
   logic signed [10:0] boost_err;
   logic signed [htc_pkg::SUM_W-1:0] shifted;

   htc_serial_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .opa    (alu_a),
      .opb    (alu_b),
      .sts    (alu_sts),
      .result (alu_r)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // temperature segment
   always_comb begin
      t_base = htc_pkg::CAL_TEMP[0];
      t_off  = '0;
      t_mulf = 11'd1;
      t_div  = 11'd1;
      if ({1'b0, meas_ff} < {1'b0, htc_pkg::CAL_ADC[0]}) begin
         t_base = htc_pkg::CAL_TEMP[0];
      end else if ({1'b0, meas_ff} <= {1'b0, htc_pkg::CAL_ADC[1]}) begin
         t_base = htc_pkg::CAL_TEMP[0];
         t_off  = meas_ff[10:0] - htc_pkg::CAL_ADC[0];
         t_mulf = htc_pkg::CAL_TEMP[1] - htc_pkg::CAL_TEMP[0];
         t_div  = htc_pkg::CAL_ADC[1] - htc_pkg::CAL_ADC[0];
      end else if ({1'b0, meas_ff} <= {1'b0, htc_pkg::CAL_ADC[2]}) begin
         t_base = htc_pkg::CAL_TEMP[1];
         t_off  = meas_ff[10:0] - htc_pkg::CAL_ADC[1];
         t_mulf = htc_pkg::CAL_TEMP[2] - htc_pkg::CAL_TEMP[1];
         t_div  = htc_pkg::CAL_ADC[2] - htc_pkg::CAL_ADC[1];
      end else if ({1'b0, meas_ff} <= {1'b0, htc_pkg::CAL_ADC[3]}) begin
         t_base = htc_pkg::CAL_TEMP[2];
         t_off  = meas_ff[10:0] - htc_pkg::CAL_ADC[2];
         t_mulf = htc_pkg::CAL_TEMP[3] - htc_pkg::CAL_TEMP[2];
         t_div  = htc_pkg::CAL_ADC[3] - htc_pkg::CAL_ADC[2];
      end else begin
         t_base = htc_pkg::CAL_TEMP[3];
      end
   end

   // target ADC segment
   always_comb begin
      s_base = htc_pkg::CAL_ADC[0];
      s_off  = '0;
      s_mulf = 11'd1;
      s_div  = 11'd1;
      if ({2'b00, sp_ff} < htc_pkg::CAL_TEMP[0]) begin
         s_base = htc_pkg::CAL_ADC[0];
      end else if ({2'b00, sp_ff} <= htc_pkg::CAL_TEMP[1]) begin
         s_base = htc_pkg::CAL_ADC[0];
         s_off  = {2'b00, sp_ff} - htc_pkg::CAL_TEMP[0];
         s_mulf = htc_pkg::CAL_ADC[1] - htc_pkg::CAL_ADC[0];
         s_div  = htc_pkg::CAL_TEMP[1] - htc_pkg::CAL_TEMP[0];
      end else if ({2'b00, sp_ff} <= htc_pkg::CAL_TEMP[2]) begin
         s_base = htc_pkg::CAL_ADC[1];
         s_off  = {2'b00, sp_ff} - htc_pkg::CAL_TEMP[1];
         s_mulf = htc_pkg::CAL_ADC[2] - htc_pkg::CAL_ADC[1];
         s_div  = htc_pkg::CAL_TEMP[2] - htc_pkg::CAL_TEMP[1];
      end else if ({2'b00, sp_ff} <= htc_pkg::CAL_TEMP[3]) begin
         s_base = htc_pkg::CAL_ADC[2];
         s_off  = {2'b00, sp_ff} - htc_pkg::CAL_TEMP[2];
         s_mulf = htc_pkg::CAL_ADC[3] - htc_pkg::CAL_ADC[2];
         s_div  = htc_pkg::CAL_TEMP[3] - htc_pkg::CAL_TEMP[2];
      end else begin
         s_base = htc_pkg::CAL_ADC[3];
      end
   end

   always_comb begin
      f_open  = (req_raw_adc >= htc_pkg::ADC_OPEN);
      f_short = (req_raw_adc <= htc_pkg::ADC_SHORT);
      scaled  = {req_raw_adc, {FILTER_SHIFT{1'b0}}};
      fdiff   = $signed({1'b0, scaled}) - $signed({1'b0, facc_ff});
      fstep   = fdiff >>> FILTER_SHIFT;
      fupd    = facc_ff + fstep[ACC_W-1:0];
      fnew    = (fault_ff || (facc_ff == '0)) ? scaled : fupd;
      boost_err = $signed({2'b00, sp_ff}) - $signed({2'b00, temp_ff});
      iacc    = $signed({{4{e_ff[12]}}, e_ff}) + $signed({integ_ff[15], integ_ff});
      if (iacc < $signed({imin_ff[15], imin_ff})) begin
         iclamp = {imin_ff[15], imin_ff};
      end else if (iacc > $signed({imax_ff[15], imax_ff})) begin
         iclamp = {imax_ff[15], imax_ff};
      end else begin
         iclamp = iacc;
      end
      dmeas   = $signed({1'b0, last_ff}) - $signed({1'b0, meas_ff});
      shifted = sum_ff >>> GAIN_SHIFT;
   end

   always_comb begin
      alu_ctl.start = 1'b0;
      alu_ctl.op    = htc_pkg::ALU_MUL;
      alu_a         = '0;
      alu_b         = '0;
      unique case (state_ff)
         ST_TMUL: begin
            alu_a = $signed({7'd0, t_off});
            alu_b = {5'd0, t_mulf};
         end
         ST_TDIV: begin
            alu_ctl.op = htc_pkg::ALU_DIV;
            alu_a = $signed({2'b00, quot_ff});
            alu_b = {5'd0, t_div};
         end
         ST_SMUL: begin
            alu_a = $signed({7'd0, s_off});
            alu_b = {5'd0, s_mulf};
         end
         ST_SDIV: begin
            alu_ctl.op = htc_pkg::ALU_DIV;
            alu_a = $signed({2'b00, quot_ff});
            alu_b = {5'd0, s_div};
         end
         ST_KP: begin
            alu_a = $signed({{5{e_ff[12]}}, e_ff});
            alu_b = kp_ff;
         end
         ST_KI: begin
            alu_a = $signed({{2{integ_ff[15]}}, integ_ff});
            alu_b = {4'd0, ki_ff};
         end
         ST_KD: begin
            alu_a = $signed({{5{dmeas[12]}}, dmeas});
            alu_b = kd_ff;
         end
         default: begin
            alu_a = '0;
         end
      endcase
      if ((state_ff == ST_TMUL) || (state_ff == ST_TDIV) || (state_ff == ST_SMUL) ||
          (state_ff == ST_SDIV) || (state_ff == ST_KP) || (state_ff == ST_KI) ||
          (state_ff == ST_KD)) begin
         alu_ctl.start = !issued_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      en_in     = en_ff;
      fault_in  = fault_ff;
      kind_in   = kind_ff;
      facc_in   = facc_ff;
      integ_in  = integ_ff;
      last_in   = last_ff;
      meas_in   = meas_ff;
      temp_in   = temp_ff;
      spadc_in  = spadc_ff;
      quot_in   = quot_ff;
      e_in      = e_ff;
      sum_in    = sum_ff;
      duty_in   = duty_ff;
      boost_in  = boost_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      o_duty_in  = o_duty_ff;
      o_meas_in  = o_meas_ff;
      o_temp_in  = o_temp_ff;
      o_en_in    = o_en_ff;
      o_fault_in = o_fault_ff;
      o_kind_in  = o_kind_ff;
      o_boost_in = o_boost_ff;
      if (alu_ctl.start) begin
         issued_in = 1'b1;
      end
      if (alu_sts.done) begin
         issued_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               duty_in  = '0;
               boost_in = 1'b0;
               if (f_open || f_short) begin
                  fault_in = 1'b1;
                  en_in    = 1'b0;
                  kind_in  = f_open;
                  facc_in  = '0;
                  meas_in  = req_raw_adc;
               end else begin
                  fault_in = 1'b0;
                  en_in    = en_ff ^ req_toggle_power;
                  kind_in  = 1'b0;
                  facc_in  = fnew;
                  meas_in  = fnew[ACC_W-1:FILTER_SHIFT];
               end
               state_in = ST_TMUL;
            end
         end
         ST_TMUL: begin
            if (alu_sts.done) begin
               quot_in  = alu_r[15:0];
               state_in = ST_TDIV;
            end
         end
         ST_TDIV: begin
            if (alu_sts.done) begin
               temp_in  = 9'(t_base + alu_r[10:0]);
               state_in = ST_SMUL;
            end
         end
         ST_SMUL: begin
            if (alu_sts.done) begin
               quot_in  = alu_r[15:0];
               state_in = ST_SDIV;
            end
         end
         ST_SDIV: begin
            if (alu_sts.done) begin
               spadc_in = s_base + alu_r[10:0];
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            e_in = $signed({2'b00, spadc_ff}) - $signed({1'b0, meas_ff});
            if (!en_ff || fault_ff) begin
               integ_in = '0;
               last_in  = meas_ff;
               state_in = ST_DONE;
            end else if (boost_err > $signed({2'b00, boost_thr_ff})) begin
               duty_in  = omax_ff;
               boost_in = 1'b1;
               integ_in = '0;
               last_in  = meas_ff;
               state_in = ST_DONE;
            end else begin
               state_in = ST_KP;
            end
         end
         ST_KP: begin
            if (alu_sts.done) begin
               sum_in   = {{(htc_pkg::SUM_W-htc_pkg::PROD_W){alu_r[htc_pkg::PROD_W-1]}}, alu_r};
               integ_in = iclamp[15:0];
               state_in = ST_KI;
            end
         end
         ST_KI: begin
            if (alu_sts.done) begin
               sum_in = sum_ff
                      + {{(htc_pkg::SUM_W-htc_pkg::PROD_W){alu_r[htc_pkg::PROD_W-1]}}, alu_r};
               state_in = ST_KD;
            end
         end
         ST_KD: begin
            if (alu_sts.done) begin
               sum_in = sum_ff
                      + {{(htc_pkg::SUM_W-htc_pkg::PROD_W){alu_r[htc_pkg::PROD_W-1]}}, alu_r};
               last_in  = meas_ff;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (shifted < 0) begin
               duty_in = '0;
            end else if (shifted > $signed({{(htc_pkg::SUM_W-10){1'b0}}, omax_ff})) begin
               duty_in = omax_ff;
            end else begin
               duty_in = shifted[9:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               o_duty_in  = duty_ff;
               o_meas_in  = meas_ff;
               o_temp_in  = temp_ff;
               o_en_in    = en_ff;
               o_fault_in = fault_ff;
               o_kind_in  = kind_ff;
               o_boost_in = boost_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_valid && csr_ready && (csr_index == htc_pkg::CSR_TARGET_C)) begin
         integ_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         en_ff        <= 1'b0;
         fault_ff     <= 1'b1;
         kind_ff      <= 1'b0;
         facc_ff      <= '0;
         integ_ff     <= '0;
         last_ff      <= '0;
         sp_ff        <= 9'd250;
         boost_thr_ff <= 9'd50;
         kp_ff        <= 16'd5120;
         ki_ff        <= 12'd14;
         kd_ff        <= 16'd51200;
         imin_ff      <= 16'sd0;
         imax_ff      <= 16'sd18267;
         omax_ff      <= 10'd999;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         en_ff        <= en_in;
         fault_ff     <= fault_in;
         kind_ff      <= kind_in;
         facc_ff      <= facc_in;
         integ_ff     <= integ_in;
         last_ff      <= last_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               htc_pkg::CSR_TARGET_C:   sp_ff        <= csr_wdata[8:0];
               htc_pkg::CSR_BOOST_THR:  boost_thr_ff <= csr_wdata[8:0];
               htc_pkg::CSR_KP:         kp_ff        <= csr_wdata;
               htc_pkg::CSR_KI:         ki_ff        <= csr_wdata[11:0];
               htc_pkg::CSR_KD:         kd_ff        <= csr_wdata;
               htc_pkg::CSR_INT_MIN:    imin_ff      <= $signed(csr_wdata);
               htc_pkg::CSR_INT_MAX:    imax_ff      <= $signed(csr_wdata);
               htc_pkg::CSR_OUTPUT_MAX: omax_ff      <= csr_wdata[9:0];
               default:                 omax_ff      <= omax_ff;
            endcase
         end
      end
      meas_ff    <= meas_in;
      temp_ff    <= temp_in;
      spadc_ff   <= spadc_in;
      quot_ff    <= quot_in;
      e_ff       <= e_in;
      sum_ff     <= sum_in;
      duty_ff    <= duty_in;
      boost_ff   <= boost_in;
      o_duty_ff  <= o_duty_in;
      o_meas_ff  <= o_meas_in;
      o_temp_ff  <= o_temp_in;
      o_en_ff    <= o_en_in;
      o_fault_ff <= o_fault_in;
      o_kind_ff  <= o_kind_in;
      o_boost_ff <= o_boost_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pwm_duty        = o_duty_ff;
   assign rsp_measured_adc    = o_meas_ff;
   assign rsp_measured_temp_c = o_temp_ff;
   assign rsp_heater_on       = o_en_ff;
   assign rsp_sensor_fault    = o_fault_ff;
   assign rsp_fault_kind      = o_kind_ff;
   assign rsp_boost_active    = o_boost_ff;

endmodule

// ===== sv/htc_serial_alu.sv =====
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
// Depends on htc_pkg.
module htc_serial_alu (
   input  logic                                clock,
   input  logic                                reset,
   input  htc_pkg::alu_ctl_type                ctl,
   input  logic signed [htc_pkg::OPA_W-1:0]    opa,
   input  logic [htc_pkg::OPB_W-1:0]           opb,
   output htc_pkg::alu_sts_type                sts,
   output logic signed [htc_pkg::PROD_W-1:0]   result
);
   logic                              busy_ff, busy_in, done_ff, done_in, op_ff, op_in;
   logic [htc_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [htc_pkg::OPA_W-1:0]         hi_ff, hi_in, a_ff, a_in;
   logic [htc_pkg::OPB_W-1:0]         lo_ff, lo_in, b_ff, b_in;
   logic [htc_pkg::OPA_W:0]           msum;
   logic [htc_pkg::OPB_W:0]           rsh;
   logic [htc_pkg::OPB_W+1:0]         rdiff;

   always_comb begin
      msum  = {hi_ff[htc_pkg::OPA_W-1], hi_ff}
            + (lo_ff[0] ? {a_ff[htc_pkg::OPA_W-1], a_ff} : '0);
      rsh   = {hi_ff[htc_pkg::OPB_W-1:0], lo_ff[htc_pkg::OPB_W-1]};
      rdiff = {1'b0, rsh} - {2'b00, b_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         cnt_in  = '1;
         hi_in   = '0;
         a_in    = opa;
         b_in    = opb;
         lo_in   = (ctl.op == htc_pkg::ALU_MUL) ? opb : opa[htc_pkg::OPB_W-1:0];
      end else if (busy_ff) begin
         if (op_ff == htc_pkg::ALU_MUL) begin
            hi_in = msum[htc_pkg::OPA_W:1];
            lo_in = {msum[0], lo_ff[htc_pkg::OPB_W-1:1]};
         end else if (!rdiff[htc_pkg::OPB_W+1]) begin
            hi_in = {{(htc_pkg::OPA_W-htc_pkg::OPB_W-1){1'b0}}, rdiff[htc_pkg::OPB_W:0]};
            lo_in = {lo_ff[htc_pkg::OPB_W-2:0], 1'b1};
         end else begin
            hi_in = {{(htc_pkg::OPA_W-htc_pkg::OPB_W-1){1'b0}}, rsh};
            lo_in = {lo_ff[htc_pkg::OPB_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = $signed({hi_ff, lo_ff});

endmodule

// ===== sv/htc_checker.sv =====
// Port-level checks of heater_temperature_controller, attached by bind.
// Depends only on the top level's ports.
module htc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic [9:0] rsp_pwm_duty,
   input logic       rsp_heater_on,
   input logic       rsp_sensor_fault,
   input logic       rsp_boost_active
);
   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second beat taken while busy");

   a_fault_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sensor_fault) |-> !rsp_heater_on)
      else $error("heater on during fault");

   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_heater_on) |-> (rsp_pwm_duty == 10'd0) && !rsp_boost_active)
      else $error("duty while heater off");

endmodule

bind heater_temperature_controller htc_checker u_htc_checker (.*);
